/* hdl/force_pi_controller_biquad_core_defines.svh */
// Assertion macros for the force PI controller.
`ifndef FORCE_PI_CONTROLLER_BIQUAD_CORE_DEFINES_SVH
`define FORCE_PI_CONTROLLER_BIQUAD_CORE_DEFINES_SVH
// Concurrent assertion on clk, disabled in reset.
`define FPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Signal holds its value on the cycle after a condition.
`define FPC_STABLE(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> $stable(sig)) \
		else $error(msg);
`endif

/* hdl/fpc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_pkg
// Types and constants for the force PI controller.
// ---------------------------------------------------------------------------
package fpc_pkg;
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int PERIOD_FRAC = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd2;
	localparam logic [23:0] PERIOD_RST = 24'd83886;
	localparam logic [30:0] KP_RST = 31'd24248320;
	localparam logic [30:0] KI_RST = 31'd229376;
	localparam logic signed [17:0] C_A2N = 18'sd61787;
	localparam logic signed [17:0] C_A3N = -18'sd21843;
	localparam logic signed [17:0] C_B1 = 18'sd6396;
	localparam logic signed [17:0] C_B2 = 18'sd12799;

	typedef struct packed {
		logic signed [DW-1:0] measured_position;
		logic signed [DW-1:0] measured_force;
		logic signed [DW-1:0] position_target;
		logic signed [DW-1:0] force_target;
		logic restart;
	} in_t;

	typedef struct packed {
		logic signed [DW-1:0] position_command;
		logic signed [DW-1:0] force_command;
		logic signed [DW-1:0] velocity_command;
		logic signed [DW-1:0] relative_error;
		logic divide_by_zero;
	} out_t;

	typedef struct packed {
		logic start;
		logic signed [64:0] num;
		logic signed [33:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic signed [63:0] quo;
	} div_rsp_t;
endpackage

/* hdl/fpc_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_div
// Radix-2 restoring divider, signed, truncating toward zero.
// ---------------------------------------------------------------------------
module fpc_div
	import fpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [64:0] q_q;
	logic [34:0] r_q;
	logic [33:0] d_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [34:0] trial;
	logic [35:0] diff;

	assign trial = {r_q[33:0], q_q[64]};
	assign diff = {1'b0, trial} - {2'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'd65;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num[64] ? -req.num : req.num;
			d_q <= req.den[33] ? -req.den : req.den;
			r_q <= '0;
			neg_q <= req.num[64] ^ req.den[33];
		end else if (busy_q) begin
			if (!diff[35]) begin
				r_q <= diff[34:0];
				q_q <= {q_q[63:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[63:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quo = neg_q ? -q_q[63:0] : q_q[63:0];
endmodule

/* hdl/force_pi_controller_biquad_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// force_pi_controller_biquad_core
// Biquad force prefilter, incremental PI velocity law, relative position error.
// ---------------------------------------------------------------------------
// channel  direction  handshake
// req_in   in         in_valid / in_stall
// res_out  out        out_valid / out_stall
// cfg      in         cfg_we / cfg_idx / cfg_data
// The result is offered once the bit-serial divider (65 steps), running beside the
// shared 34x34 multiplier (ten products), has finished.
// in_stall is high from acceptance until the result leaves the output register.
// Reset clears all history, the gain enable and the registers to defaults.
// ---------------------------------------------------------------------------
module force_pi_controller_biquad_core
	import fpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_UPD  = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT  = 5'b10000
	} st_t;

	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	st_t st_q;
	logic [3:0] step_q;
	logic [23:0] period_q;
	logic [30:0] kp_q, ki_q;
	logic en_q;
	logic signed [31:0] x1_q, x2_q, y1_q, y2_q, pe_q, vel_q;
	logic signed [31:0] fcmd_q, y_q, e_q;
	logic [39:0] kit_q;
	logic signed [63:0] acc_q;
	in_t in_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic signed [63:0] pshift, yrnd, esat, vsum;
	logic signed [32:0] ediff;

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		if (v > SMAX) return 32'sh7fffffff;
		if (v < SMIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	assign ediff = {e_q[31], e_q} - {pe_q[31], pe_q};

	// step: 0-4 filter taps, 5 Ki*T, 6/7 Kp hi/lo, 8/9 KiT hi/lo
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			4'd0: begin ma = 34'(C_A2N); mb = 34'(y1_q); end
			4'd1: begin ma = 34'(C_A3N); mb = 34'(y2_q); end
			4'd2: begin ma = 34'(C_B1); mb = 34'(in_q.measured_force); end
			4'd3: begin ma = 34'(C_B2); mb = 34'(x1_q); end
			4'd4: begin ma = 34'(C_B1); mb = 34'(x2_q); end
			4'd5: begin ma = {3'b0, ki_q}; mb = {10'b0, period_q}; end
			4'd6: begin ma = {19'b0, kp_q[30:16]}; mb = 34'(ediff); end
			4'd7: begin ma = {18'b0, kp_q[15:0]}; mb = 34'(ediff); end
			4'd8: begin ma = {10'b0, kit_q[39:16]}; mb = 34'(e_q); end
			4'd9: begin ma = {18'b0, kit_q[15:0]}; mb = 34'(e_q); end
			default: ;
		endcase
	end
	assign prod = ma * mb;
	assign pshift = ($signed(prod[63:0]) + 64'sd32768) >>> 16;
	assign yrnd = (acc_q + 64'sd32768) >>> 16;
	assign esat = 64'(fcmd_q) - 64'(sat(yrnd));
	assign vsum = 64'(vel_q) + acc_q;

	always_comb begin
		dreq.start = (st_q == S_IDLE) && in_valid;
		dreq.num = 65'($signed({in_data.measured_position[31], in_data.measured_position}
			- {in_data.position_target[31], in_data.position_target})) <<< 16;
		dreq.den = 34'(in_data.position_target);
	end

	fpc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			step_q <= '0;
			period_q <= PERIOD_RST;
			kp_q <= KP_RST;
			ki_q <= KI_RST;
			en_q <= 1'b0;
			x1_q <= '0; x2_q <= '0; y1_q <= '0; y2_q <= '0;
			pe_q <= '0; vel_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_PERIOD: period_q <= cfg_data[23:0];
					REG_KP: kp_q <= cfg_data;
					REG_KI: ki_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					st_q <= S_MUL;
					step_q <= '0;
					en_q <= en_q | in_data.restart;
				end
				S_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd4) st_q <= S_UPD;
					if (step_q == 4'd9) st_q <= S_WAIT;
				end
				S_UPD: begin
					st_q <= S_MUL;
					step_q <= 4'd5;
				end
				S_WAIT: if (!drsp.busy) begin
					st_q <= S_OUT;
					vel_q <= sat(vsum);
					pe_q <= e_q;
					x2_q <= x1_q; x1_q <= in_q.measured_force;
					y2_q <= y1_q; y1_q <= y_q;
				end
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				in_q <= in_data;
				fcmd_q <= (en_q | in_data.restart) ? in_data.force_target : '0;
				acc_q <= '0;
			end
			S_MUL: begin
				unique case (step_q)
					4'd5: kit_q <= 40'((prod[63:0] + 64'sd8388608) >>> PERIOD_FRAC);
					4'd6, 4'd8: acc_q <= acc_q + prod[63:0];
					4'd7, 4'd9: acc_q <= acc_q + pshift;
					default: acc_q <= acc_q + prod[63:0];
				endcase
			end
			S_UPD: begin
				y_q <= sat(yrnd);
				e_q <= sat(esat);
				acc_q <= '0;
			end
			default: ;
		endcase
	end

	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);
	always_comb begin
		out_data.position_command = in_q.position_target;
		out_data.force_command = fcmd_q;
		out_data.velocity_command = vel_q;
		out_data.divide_by_zero = (in_q.position_target == '0);
		out_data.relative_error = out_data.divide_by_zero ? '0 : sat(drsp.quo);
	end
endmodule

/* hdl/fpc_checker.sv */
`timescale 1ns / 1ps
`include "force_pi_controller_biquad_core_defines.svh"
// ---------------------------------------------------------------------------
// fpc_checker
// Port-level checks on the force PI controller.
// ---------------------------------------------------------------------------
module fpc_checker
	import fpc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);
	`FPC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output dropped")
	`FPC_STABLE(a_out_stable, out_valid && out_stall, out_data, "output moved")
	`FPC_ASSERT(a_busy_on_out, out_valid |-> in_stall, "request taken while result pending")
	`FPC_ASSERT(a_take_stalls, in_valid && !in_stall |=> in_stall, "not busy after request")
	`FPC_ASSERT(a_dz_zero, out_valid && out_data.divide_by_zero |-> out_data.relative_error == '0, "dz error")
endmodule

bind force_pi_controller_biquad_core fpc_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data));

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives control ticks into the force PI controller with random gaps and
// output stalls, predicts each result in step with the block's own state and
// registers, and compares every field of every result in order.
// ---------------------------------------------------------------------------
module testbench;
	import fpc_pkg::*;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	force_pi_controller_biquad_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// controller mirror
	longint unsigned period_q, kp_q, ki_q;
	bit enabled;
	longint raw_h0, raw_h1, filt_h0, filt_h1, prev_err, vel_acc;

	out_t expected_q[$];
	int errors = 0;
	bit hold_long = 1'b0;
	bit stim_done = 1'b0;

	typedef struct {
		in_t req;
		bit has_exp;
		out_t exp;
	} row_t;
	row_t rows[$];

	function automatic longint sat32(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint rnd_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint scale_gain(longint unsigned g, longint x);
		longint gh, gl;
		gh = longint'(g >> FB);
		gl = longint'(g & ((64'd1 << FB) - 1));
		return gh * x + rnd_shift(gl * x, FB);
	endfunction

	function automatic void reset_mirror();
		period_q = PERIOD_RST;
		kp_q = KP_RST;
		ki_q = KI_RST;
		enabled = 0;
		raw_h0 = 0; raw_h1 = 0; filt_h0 = 0; filt_h1 = 0;
		prev_err = 0; vel_acc = 0;
	endfunction

	function automatic out_t predict_tick(in_t r);
		out_t o;
		longint pos, frc, pt, ft, fcmd, y, e, p, kit, i, rel;
		pos = longint'(r.measured_position);
		frc = longint'(r.measured_force);
		pt = longint'(r.position_target);
		ft = longint'(r.force_target);
		if (r.restart) enabled = 1;
		fcmd = enabled ? ft : 0;
		y = 64'sd61787 * filt_h0 - 64'sd21843 * filt_h1 + 64'sd6396 * frc
			+ 64'sd12799 * raw_h0 + 64'sd6396 * raw_h1;
		y = sat32(rnd_shift(y, 16));
		e = sat32(fcmd - y);
		p = scale_gain(kp_q, e - prev_err);
		kit = longint'((ki_q * period_q + (64'd1 << (PERIOD_FRAC - 1))) >> PERIOD_FRAC);
		i = scale_gain(longint'(kit), e);
		vel_acc = sat32(vel_acc + p + i);
		raw_h1 = raw_h0; raw_h0 = frc;
		filt_h1 = filt_h0; filt_h0 = y;
		prev_err = e;
		if (pt == 0) rel = 0;
		else rel = sat32(((pos - pt) * 65536) / pt);
		o.position_command = r.position_target;
		o.force_command = fcmd[31:0];
		o.velocity_command = vel_acc[31:0];
		o.relative_error = rel[31:0];
		o.divide_by_zero = (pt == 0);
		return o;
	endfunction

	task automatic send_tick(in_t r, bit has_exp, out_t exp);
		out_t o;
		int gap;
		gap = $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		o = predict_tick(r);
		if (has_exp && o !== exp) begin
			$display("%0t table row disagrees: table %h predictor %h", $time, exp, o);
			errors++;
		end
		expected_q.push_back(o);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PERIOD) period_q = v & 64'hFFFFFF;
		else if (idx == REG_KP) kp_q = v & 64'h7FFFFFFF;
		else if (idx == REG_KI) ki_q = v & 64'h7FFFFFFF;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t rand_tick();
		in_t r;
		r.measured_position = rand_word();
		r.measured_force = rand_word();
		r.position_target = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
		r.force_target = rand_word();
		r.restart = ($urandom_range(0, 7) == 0);
		return r;
	endfunction

	function automatic void add_row(logic [31:0] mp, logic [31:0] mf, logic [31:0] pt,
			logic [31:0] ft, bit rs, bit he, out_t ex);
		row_t w;
		w.req = '{mp, mf, pt, ft, rs};
		w.has_exp = he;
		w.exp = ex;
		rows.push_back(w);
	endfunction

	// receiver
	initial begin
		out_t got, exp;
		int wait_n;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_long = 1'b0;
			end
			wait_n = $urandom_range(0, 11);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = out_data;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				exp = expected_q.pop_front();
				if (got.position_command !== exp.position_command) begin
					$display("%0t position_command exp %h got %h", $time,
						exp.position_command, got.position_command);
					errors++;
				end
				if (got.force_command !== exp.force_command) begin
					$display("%0t force_command exp %h got %h", $time,
						exp.force_command, got.force_command);
					errors++;
				end
				if (got.velocity_command !== exp.velocity_command) begin
					$display("%0t velocity_command exp %h got %h", $time,
						exp.velocity_command, got.velocity_command);
					errors++;
				end
				if (got.relative_error !== exp.relative_error) begin
					$display("%0t relative_error exp %h got %h", $time,
						exp.relative_error, got.relative_error);
					errors++;
				end
				if (got.divide_by_zero !== exp.divide_by_zero) begin
					$display("%0t divide_by_zero exp %b got %b", $time,
						exp.divide_by_zero, got.divide_by_zero);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		out_t none;
		none = '0;
		reset_mirror();
		// zero input after reset: everything zero, divide by zero flagged
		add_row(32'h0, 32'h0, 32'h0, 32'h0, 0, 1, '{0, 0, 0, 0, 1'b1});
		// target not yet enabled: force command zero
		add_row(32'h00010000, 32'h0, 32'h00010000, 32'h00050000, 0, 1,
			'{32'h00010000, 0, 0, 0, 1'b0});
		add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, none);
		add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, none);
		add_row(32'h7FFFFFFF, 32'h0, 32'h00000001, 32'h0, 1, 0, none);
		add_row(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 0, 0, none);
		add_row(32'h80000000, 32'h80000000, 32'h00000001, 32'h80000000, 0, 0, none);
		add_row(32'h00030000, 32'h00020000, 32'h0, 32'hFFFF0000, 0, 0, none);
		add_row(32'h00020000, 32'h00010000, 32'h00010000, 32'h00020000, 1, 0, none);
		add_row(32'hFFFE0000, 32'hFFFF8000, 32'hFFFF0000, 32'h00000000, 0, 0, none);
		for (int k = 0; k < 6; k++)
			add_row(32'h7FFFFFFF, 32'h80000000, 32'h00000002, 32'h7FFFFFFF, 0, 0, none);
		for (int k = 0; k < 6; k++)
			add_row(32'h80000000, 32'h7FFFFFFF, 32'h00000002, 32'h80000000, 0, 0, none);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[k]) send_tick(rows[k].req, rows[k].has_exp, rows[k].exp);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_PERIOD, 64'hFFFFFF);
					write_reg(REG_KP, 64'h7FFFFFFF);
					write_reg(REG_KI, 64'h7FFFFFFF);
				end
				1: begin
					write_reg(REG_PERIOD, 1);
					write_reg(REG_KP, 0);
					write_reg(REG_KI, 0);
				end
				2: write_reg(REG_PERIOD, 0);
				3: begin
					write_reg(REG_PERIOD, 3);
					write_reg(REG_KP, $urandom_range(0, 32'h7FFFFFFF));
					write_reg(REG_KI, $urandom_range(0, 32'h7FFFFFFF));
				end
				4: begin
					write_reg(REG_PERIOD, PERIOD_RST);
					write_reg(REG_KP, KP_RST);
					write_reg(REG_KI, KI_RST);
				end
				default: begin
					write_reg(REG_PERIOD, $urandom_range(1, 24'hFFFFFF));
					write_reg(REG_KP, $urandom_range(0, 32'h000FFFFF));
					write_reg(REG_KI, $urandom_range(0, 32'h000FFFFF));
				end
			endcase
			if (ph == 2) hold_long = 1'b1;
			for (int k = 0; k < 150; k++) send_tick(rand_tick(), 0, '0);
			drain();
		end

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+hdl
hdl/fpc_pkg.sv
hdl/fpc_div.sv
hdl/force_pi_controller_biquad_core.sv
hdl/fpc_checker.sv
bench/testbench.sv
